[rtl/tps_pkg.sv]
package tps_pkg;

  localparam int unsigned PATTERN_LENGTH = 8;
  localparam int unsigned NUM_NOTES      = 5;
  localparam int unsigned HZ_W           = 12;
  localparam int unsigned DUR_W          = 10;
  localparam int unsigned IDX_W          = 4;

  localparam logic [DUR_W-1:0] ELAPSED_MAX = 10'd1023;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic [2:0] JINGLE_CAL     = 3'd0;
  localparam logic [2:0] JINGLE_SUCCESS = 3'd1;
  localparam logic [2:0] JINGLE_ERROR   = 3'd2;
  localparam logic [2:0] JINGLE_WARNING = 3'd3;

  localparam logic [1:0] PAT_CAL     = 2'd0;
  localparam logic [1:0] PAT_SUCCESS = 2'd1;
  localparam logic [1:0] PAT_ERROR   = 2'd2;
  localparam logic [1:0] PAT_WARNING = 2'd3;

  localparam logic [2:0] NOTE_SILENT = 3'd0;
  localparam logic [2:0] NOTE_C4     = 3'd1;
  localparam logic [2:0] NOTE_E4     = 3'd2;
  localparam logic [2:0] NOTE_G4     = 3'd3;
  localparam logic [2:0] NOTE_C5     = 3'd4;
  localparam logic [2:0] NOTE_A4     = 3'd5;

  localparam logic [2:0] REG_C4 = 3'd0;
  localparam logic [2:0] REG_E4 = 3'd1;
  localparam logic [2:0] REG_G4 = 3'd2;
  localparam logic [2:0] REG_C5 = 3'd3;
  localparam logic [2:0] REG_A4 = 3'd4;

  localparam logic [HZ_W-1:0] RST_C4_HZ = 12'd262;
  localparam logic [HZ_W-1:0] RST_E4_HZ = 12'd330;
  localparam logic [HZ_W-1:0] RST_G4_HZ = 12'd392;
  localparam logic [HZ_W-1:0] RST_C5_HZ = 12'd523;
  localparam logic [HZ_W-1:0] RST_A4_HZ = 12'd440;

  typedef logic [NUM_NOTES-1:0][HZ_W-1:0] note_bank_t;

  typedef struct packed {
    logic [2:0]       note;
    logic [DUR_W-1:0] dur;
  } step_t;

  typedef struct packed {
    logic             active;
    logic [1:0]       sel;
    logic [IDX_W-1:0] limit;
    logic [IDX_W-1:0] idx;
    logic [DUR_W-1:0] elapsed;
  } seq_state_t;

  typedef struct packed {
    logic             start_ignored;
    logic [2:0]       step_now;
    logic             playing;
    logic [HZ_W-1:0]  tone_hz;
  } out_beat_t;

  function automatic step_t step_lookup(input logic [1:0] sel, input logic [IDX_W-1:0] idx);
    step_t s;
    s = '{note: NOTE_SILENT, dur: '0};
    case (sel)
      PAT_CAL: begin
        case (idx)
          4'd0: s = '{note: NOTE_C4, dur: 10'd100};
          4'd1: s = '{note: NOTE_SILENT, dur: 10'd50};
          4'd2: s = '{note: NOTE_E4, dur: 10'd100};
          4'd3: s = '{note: NOTE_SILENT, dur: 10'd50};
          4'd4: s = '{note: NOTE_G4, dur: 10'd100};
          4'd5: s = '{note: NOTE_SILENT, dur: 10'd100};
          4'd6: s = '{note: NOTE_C5, dur: 10'd500};
          default: s = '{note: NOTE_SILENT, dur: '0};
        endcase
      end
      PAT_SUCCESS: begin
        case (idx)
          4'd0: s = '{note: NOTE_C4, dur: 10'd150};
          4'd1: s = '{note: NOTE_SILENT, dur: 10'd50};
          4'd2: s = '{note: NOTE_E4, dur: 10'd150};
          4'd3: s = '{note: NOTE_SILENT, dur: 10'd50};
          4'd4: s = '{note: NOTE_G4, dur: 10'd300};
          default: s = '{note: NOTE_SILENT, dur: '0};
        endcase
      end
      PAT_ERROR: begin
        case (idx)
          4'd0: s = '{note: NOTE_G4, dur: 10'd300};
          4'd1: s = '{note: NOTE_SILENT, dur: 10'd50};
          4'd2: s = '{note: NOTE_E4, dur: 10'd150};
          4'd3: s = '{note: NOTE_SILENT, dur: 10'd50};
          4'd4: s = '{note: NOTE_C4, dur: 10'd100};
          default: s = '{note: NOTE_SILENT, dur: '0};
        endcase
      end
      default: begin
        case (idx)
          4'd0: s = '{note: NOTE_A4, dur: 10'd200};
          4'd1: s = '{note: NOTE_SILENT, dur: 10'd200};
          4'd2: s = '{note: NOTE_A4, dur: 10'd200};
          default: s = '{note: NOTE_SILENT, dur: '0};
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [DUR_W-1:0] step_dur_of(input logic [1:0] sel,
                                                   input logic [IDX_W-1:0] idx);
    step_t s;
    s = step_lookup(sel, idx);
    return s.dur;
  endfunction

endpackage

[rtl/tone_pattern_sequencer.sv]
// Buzzer jingle sequencer. Each input beat carries a command in in_tuser (0 = one
// millisecond tick, 1 = start) and a jingle code in in_tdata (0 calibration, 1 success,
// 2 error, 3 warning, 4..7 short beep); every input beat yields exactly one output beat
// with the tone to drive now (0 = silent), a playing flag, the current step and a flag
// set when a start arrives during playback and is dropped. One beat is taken per clock;
// the sequencer state and the result are updated in the cycle a beat is accepted and the
// result sits in a two-entry output buffer, so input stalls only when two results are
// waiting. Note frequencies are written through the cfg port (index 0 C4, 1 E4, 2 G4,
// 3 C5, 4 A4; other indexes are dropped) and should only change while the block is idle.
module tone_pattern_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] jingle
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [11:0] tone_hz, [12] playing, [15:13] step_now,
                                  // [16] start_ignored
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  tps_pkg::seq_state_t state_r;
  tps_pkg::seq_state_t state_nxt;
  tps_pkg::note_bank_t notes_r;
  tps_pkg::out_beat_t  res_beat;
  tps_pkg::out_beat_t  head_beat;
  logic                in_fire;
  logic                out_fire;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  tps_step u_step (
    .cur    (state_r),
    .cmd    (in_tuser),
    .jingle (in_tdata[2:0]),
    .notes  (notes_r),
    .nxt    (state_nxt),
    .beat   (res_beat)
  );

  tps_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_beat (res_beat),
    .ready     (in_tready),
    .valid     (out_tvalid),
    .pop       (out_fire),
    .head      (head_beat)
  );

  assign out_tdata = {7'd0, head_beat.start_ignored, head_beat.step_now,
                      head_beat.playing, head_beat.tone_hz};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notes_r[tps_pkg::REG_C4] <= tps_pkg::RST_C4_HZ;
      notes_r[tps_pkg::REG_E4] <= tps_pkg::RST_E4_HZ;
      notes_r[tps_pkg::REG_G4] <= tps_pkg::RST_G4_HZ;
      notes_r[tps_pkg::REG_C5] <= tps_pkg::RST_C5_HZ;
      notes_r[tps_pkg::REG_A4] <= tps_pkg::RST_A4_HZ;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tps_pkg::REG_C4: notes_r[tps_pkg::REG_C4] <= cfg_data;
        tps_pkg::REG_E4: notes_r[tps_pkg::REG_E4] <= cfg_data;
        tps_pkg::REG_G4: notes_r[tps_pkg::REG_G4] <= cfg_data;
        tps_pkg::REG_C5: notes_r[tps_pkg::REG_C5] <= cfg_data;
        tps_pkg::REG_A4: notes_r[tps_pkg::REG_A4] <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idx_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.active |-> state_r.idx < state_r.limit)
    else $error("active step index at or past limit");

  a_step_has_dur: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.active |-> tps_pkg::step_dur_of(state_r.sel, state_r.idx) != '0)
    else $error("active step has zero duration");

  a_elapsed_below_dur: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.active |-> state_r.elapsed < tps_pkg::step_dur_of(state_r.sel, state_r.idx))
    else $error("elapsed time reached step duration without advancing");

  a_ignored_start_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == tps_pkg::CMD_START && state_r.active) |=>
      ($stable(state_r.idx) && $stable(state_r.elapsed) && $stable(state_r.sel)))
    else $error("dropped start changed sequencer state");
`endif

endmodule

[rtl/tps_step.sv]
module tps_step (
  input  tps_pkg::seq_state_t cur,
  input  logic                cmd,
  input  logic [2:0]          jingle,
  input  tps_pkg::note_bank_t notes,
  output tps_pkg::seq_state_t nxt,
  output tps_pkg::out_beat_t  beat
);

  tps_pkg::step_t               cur_step;
  tps_pkg::step_t               look_step;
  tps_pkg::step_t               new_step;
  logic [tps_pkg::IDX_W:0]      idx_inc;
  logic [tps_pkg::IDX_W:0]      nom_lim;
  logic [tps_pkg::IDX_W:0]      lim_clamped;
  logic [tps_pkg::DUR_W-1:0]    el_inc;
  logic [1:0]                   start_sel;
  logic                         ignored;
  logic [tps_pkg::HZ_W-1:0]     hz;

  assign cur_step  = tps_pkg::step_lookup(cur.sel, cur.idx);
  assign idx_inc   = {1'b0, cur.idx} + 5'd1;
  assign look_step = tps_pkg::step_lookup(cur.sel, idx_inc[tps_pkg::IDX_W-1:0]);
  assign el_inc    = (cur.elapsed < tps_pkg::ELAPSED_MAX) ? cur.elapsed + 10'd1 : cur.elapsed;

  always_comb begin
    unique case (jingle)
      tps_pkg::JINGLE_CAL: begin
        start_sel = tps_pkg::PAT_CAL;
        nom_lim   = 5'd8;
      end
      tps_pkg::JINGLE_SUCCESS: begin
        start_sel = tps_pkg::PAT_SUCCESS;
        nom_lim   = 5'd6;
      end
      tps_pkg::JINGLE_ERROR: begin
        start_sel = tps_pkg::PAT_ERROR;
        nom_lim   = 5'd6;
      end
      tps_pkg::JINGLE_WARNING: begin
        start_sel = tps_pkg::PAT_WARNING;
        nom_lim   = 5'd4;
      end
      default: begin
        start_sel = tps_pkg::PAT_WARNING;
        nom_lim   = 5'd2;
      end
    endcase
    lim_clamped = (nom_lim > 5'(tps_pkg::PATTERN_LENGTH)) ?
                  5'(tps_pkg::PATTERN_LENGTH) : nom_lim;
  end

  always_comb begin
    nxt     = cur;
    ignored = 1'b0;
    if (cmd == tps_pkg::CMD_START) begin
      if (cur.active) begin
        ignored = 1'b1;
      end else begin
        nxt.active  = 1'b1;
        nxt.sel     = start_sel;
        nxt.limit   = lim_clamped[tps_pkg::IDX_W-1:0];
        nxt.idx     = '0;
        nxt.elapsed = '0;
      end
    end else if (cur.active) begin
      nxt.elapsed = el_inc;
      if (el_inc >= cur_step.dur) begin
        nxt.idx = idx_inc[tps_pkg::IDX_W-1:0];
        if (idx_inc >= {1'b0, cur.limit} || idx_inc[tps_pkg::IDX_W] ||
            look_step.dur == '0) begin
          nxt.active = 1'b0;
        end else begin
          nxt.elapsed = '0;
        end
      end
    end
  end

  assign new_step = tps_pkg::step_lookup(nxt.sel, nxt.idx);

  always_comb begin
    unique case (new_step.note)
      tps_pkg::NOTE_C4: hz = notes[tps_pkg::REG_C4];
      tps_pkg::NOTE_E4: hz = notes[tps_pkg::REG_E4];
      tps_pkg::NOTE_G4: hz = notes[tps_pkg::REG_G4];
      tps_pkg::NOTE_C5: hz = notes[tps_pkg::REG_C5];
      tps_pkg::NOTE_A4: hz = notes[tps_pkg::REG_A4];
      default:          hz = '0;
    endcase
  end

  always_comb begin
    beat.start_ignored = ignored;
    beat.playing       = nxt.active;
    beat.step_now      = nxt.active ? nxt.idx[2:0] : 3'd0;
    beat.tone_hz       = nxt.active ? hz : '0;
  end

endmodule

[rtl/tps_obuf.sv]
module tps_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tps_pkg::out_beat_t push_beat,
  output logic               ready,
  output logic               valid,
  input  logic               pop,
  output tps_pkg::out_beat_t head
);

  tps_pkg::out_beat_t head_r;
  tps_pkg::out_beat_t tail_r;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;

  assign ready = (cnt_r != 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = head_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      head_r <= push_beat;
    end else if (pop && cnt_r == 2'd2) begin
      head_r <= tail_r;
    end
    if (push && cnt_r == 2'd1 && !pop) begin
      tail_r <= push_beat;
    end
  end

endmodule

[tb/tb_tone_pattern_sequencer.sv]
`timescale 1ns / 100ps

module tb_tone_pattern_sequencer;
  import tps_pkg::*;

  class tone_scoreboard;
    logic [HZ_W-1:0]  note_hz [NUM_NOTES];
    bit               active;
    logic [1:0]       sel;
    logic [IDX_W-1:0] limit;
    logic [IDX_W-1:0] idx;
    logic [DUR_W-1:0] elapsed;
    logic [2:0]       tbl_note [4][8];
    int               tbl_dur [4][8];
    out_beat_t        tone_q [$];
    int               fails;

    function new();
      note_hz[REG_C4] = 12'd262;
      note_hz[REG_E4] = 12'd330;
      note_hz[REG_G4] = 12'd392;
      note_hz[REG_C5] = 12'd523;
      note_hz[REG_A4] = 12'd440;
      active  = 1'b0;
      sel     = PAT_CAL;
      limit   = '0;
      idx     = '0;
      elapsed = '0;
      fails   = 0;
      tbl_note = '{
        '{NOTE_C4, NOTE_SILENT, NOTE_E4, NOTE_SILENT, NOTE_G4, NOTE_SILENT, NOTE_C5, NOTE_SILENT},
        '{NOTE_C4, NOTE_SILENT, NOTE_E4, NOTE_SILENT, NOTE_G4, NOTE_SILENT, NOTE_SILENT,
          NOTE_SILENT},
        '{NOTE_G4, NOTE_SILENT, NOTE_E4, NOTE_SILENT, NOTE_C4, NOTE_SILENT, NOTE_SILENT,
          NOTE_SILENT},
        '{NOTE_A4, NOTE_SILENT, NOTE_A4, NOTE_SILENT, NOTE_SILENT, NOTE_SILENT, NOTE_SILENT,
          NOTE_SILENT}
      };
      tbl_dur = '{
        '{100, 50, 100, 50, 100, 100, 500, 0},
        '{150, 50, 150, 50, 300, 0, 0, 0},
        '{300, 50, 150, 50, 100, 0, 0, 0},
        '{200, 200, 200, 0, 0, 0, 0, 0}
      };
    endfunction

    function void write_note(logic [2:0] index, logic [HZ_W-1:0] value);
      if (index <= REG_A4) note_hz[index] = value;
    endfunction

    function int step_dur(logic [1:0] pat, int step);
      if (step >= 8) return 0;
      return tbl_dur[pat][step];
    endfunction

    function logic [HZ_W-1:0] step_hz(logic [1:0] pat, int step);
      logic [2:0] code;
      code = (step >= 8) ? NOTE_SILENT : tbl_note[pat][step];
      case (code)
        NOTE_C4: return note_hz[REG_C4];
        NOTE_E4: return note_hz[REG_E4];
        NOTE_G4: return note_hz[REG_G4];
        NOTE_C5: return note_hz[REG_C5];
        NOTE_A4: return note_hz[REG_A4];
        default: return '0;
      endcase
    endfunction

    function void note_beat(logic cmd, logic [2:0] jingle);
      out_beat_t tone;
      bit        ign;
      int        lim;
      int        nxt;
      ign = 1'b0;
      if (cmd == CMD_START) begin
        if (active) begin
          ign = 1'b1;
        end else begin
          case (jingle)
            JINGLE_CAL:     begin sel = PAT_CAL;     lim = 8; end
            JINGLE_SUCCESS: begin sel = PAT_SUCCESS; lim = 6; end
            JINGLE_ERROR:   begin sel = PAT_ERROR;   lim = 6; end
            JINGLE_WARNING: begin sel = PAT_WARNING; lim = 4; end
            default:        begin sel = PAT_WARNING; lim = 2; end
          endcase
          if (lim > PATTERN_LENGTH) lim = PATTERN_LENGTH;
          limit   = lim[IDX_W-1:0];
          idx     = '0;
          elapsed = '0;
          active  = 1'b1;
        end
      end else if (active) begin
        if (elapsed < ELAPSED_MAX) elapsed = elapsed + 1'b1;
        if (int'(elapsed) >= step_dur(sel, int'(idx))) begin
          nxt = int'(idx) + 1;
          if (nxt >= int'(limit) || nxt >= 16 || step_dur(sel, nxt) == 0) begin
            active = 1'b0;
            idx    = nxt[IDX_W-1:0];
          end else begin
            idx     = nxt[IDX_W-1:0];
            elapsed = '0;
          end
        end
      end
      tone = '0;
      if (active) begin
        tone.tone_hz  = step_hz(sel, int'(idx));
        tone.playing  = 1'b1;
        tone.step_now = idx[2:0];
      end
      tone.start_ignored = ign;
      tone_q.push_back(tone);
    endfunction

    function void check_beat(logic [23:0] data);
      out_beat_t got;
      out_beat_t want;
      got = out_beat_t'(data[16:0]);
      if (tone_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, data);
        fails++;
        return;
      end
      want = tone_q.pop_front();
      if (got.tone_hz !== want.tone_hz) begin
        $display("%0t: tone_hz expected %0d got %0d", $time, want.tone_hz, got.tone_hz);
        fails++;
      end
      if (got.playing !== want.playing) begin
        $display("%0t: playing expected %0d got %0d", $time, want.playing, got.playing);
        fails++;
      end
      if (got.step_now !== want.step_now) begin
        $display("%0t: step_now expected %0d got %0d", $time, want.step_now, got.step_now);
        fails++;
      end
      if (got.start_ignored !== want.start_ignored) begin
        $display("%0t: start_ignored expected %0d got %0d", $time, want.start_ignored,
                 got.start_ignored);
        fails++;
      end
    endfunction

    function int pending();
      return tone_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;

  tone_scoreboard sb = new();
  bit in_burst;
  bit out_burst;
  int beats_sent;

  tone_pattern_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(logic cmd, logic [2:0] jingle);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, jingle};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(cmd, jingle);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] index, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_note(index, value);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [11:0] pick_hz();
    case ($urandom_range(0, 3))
      0:       return 12'd0;
      1:       return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic retune_notes(bit extremes);
    if (extremes) begin
      write_cfg(REG_C4, 12'd0);
      write_cfg(REG_E4, 12'hfff);
      write_cfg(REG_G4, 12'hfff);
      write_cfg(REG_C5, 12'd0);
      write_cfg(REG_A4, 12'hfff);
      write_cfg(3'd5, 12'($urandom));
      write_cfg(3'd7, 12'($urandom));
    end else begin
      for (int i = 0; i < NUM_NOTES; i++) begin
        if ($urandom_range(0, 3) != 0) write_cfg(3'(i), pick_hz());
      end
      if ($urandom_range(0, 3) == 0) write_cfg(3'($urandom_range(5, 7)), 12'($urandom));
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // output side: random stalls, check each accepted beat
  initial begin
    int stall;
    out_tready = 1'b0;
    out_burst  = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && out_tready));
      sb.check_beat(out_tdata);
      @(negedge clk);
    end
  end

  initial begin
    bit first;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TICK;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_burst   = 1'b0;
    beats_sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle ticks, beep through code 7, starts during playback
    send_beat(CMD_TICK, 3'd0);
    send_beat(CMD_TICK, 3'd7);
    send_beat(CMD_START, 3'd7);
    for (int j = 0; j < 8; j++) send_beat(CMD_START, 3'(j));
    repeat (5) send_beat(CMD_TICK, 3'($urandom));

    beats_sent = 0;
    first = 1'b1;
    while (beats_sent < 1950) begin
      while (sb.active) begin
        if ($urandom_range(0, 29) == 0) send_beat(CMD_START, 3'($urandom));
        else send_beat(CMD_TICK, 3'($urandom));
      end
      repeat ($urandom_range(0, 3)) send_beat(CMD_TICK, 3'($urandom));
      if (first || $urandom_range(0, 2) == 0) begin
        drain_results();
        retune_notes(first);
      end
      send_beat(CMD_START, first ? JINGLE_CAL : 3'($urandom_range(0, 7)));
      first = 1'b0;
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tps_pkg.sv
rtl/tps_step.sv
rtl/tps_obuf.sv
rtl/tone_pattern_sequencer.sv
tb/tb_tone_pattern_sequencer.sv
